// File: hw/rtl/ptw_pkg.sv
// ptw_pkg: shared constants and helpers for the page table walker
// no dependencies; used by the interfaces, the sequencer and the top level
`default_nettype none

package ptw_pkg;

	localparam int VA_W          = 48;
	localparam int PA_W          = 52;
	localparam int FLAGS_W       = 64;
	localparam int ENTRY_W       = 64;
	localparam int PAGE_OFS_W    = 12;
	localparam int FRAME_NUM_W   = 40;
	localparam int ENTRY_IDX_W   = 9;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int LEVEL_W       = 2;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int CFG_W         = 6;
	localparam int CFG_IDX_W     = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE = 1'b1;

	localparam logic [CFG_W-1:0] ROOT_FRAME_RESET = 6'd0;
	localparam logic [CFG_W-1:0] ALLOC_BASE_RESET = 6'd1;

	// request operation codes
	localparam logic [OP_W-1:0] OP_MAP     = 2'd0;
	localparam logic [OP_W-1:0] OP_UNMAP   = 2'd1;
	localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 2'd2;

	localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

	// entry bits
	localparam int PTE_PRESENT = 0;
	localparam int PTE_WRITE   = 1;

	// table index of a virtual address at one level of the walk
	function automatic logic [ENTRY_IDX_W-1:0] level_index(
		input logic [VA_W-1:0]    va,
		input logic [LEVEL_W-1:0] level
	);
		logic [ENTRY_IDX_W-1:0] idx;
		unique case (level)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ptw_if.sv
// ptw_if: request, response and configuration channel interfaces
// depends on ptw_pkg for field widths
`default_nettype none

interface ptw_req_if;
	logic                          valid;
	logic                          ready;
	logic [ptw_pkg::OP_W-1:0]      operation;
	logic [ptw_pkg::VA_W-1:0]      virt_addr;
	logic [ptw_pkg::PA_W-1:0]      phys_addr;
	logic [ptw_pkg::FLAGS_W-1:0]   entry_flags;

	modport source (output valid, operation, virt_addr, phys_addr,
		entry_flags, input ready);
	modport sink (input valid, operation, virt_addr, phys_addr,
		entry_flags, output ready);
endinterface

interface ptw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ptw_pkg::STATUS_W-1:0]  status;
	logic [ptw_pkg::PA_W-1:0]      translated_address;
	logic                          tlb_invalidate;

	modport source (output valid, status, translated_address, tlb_invalidate,
		input ready);
	modport sink (input valid, status, translated_address, tlb_invalidate,
		output ready);
endinterface

interface ptw_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ptw_pkg::CFG_IDX_W-1:0] index;
	logic [ptw_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ptw_store.sv
// ptw_store: frame store memory, one port, registered read data
// no package dependencies
`default_nettype none

module ptw_store #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 64
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/ptw_frame_mod.sv
// ptw_frame_mod: reduces a 40-bit frame number modulo the store size
// depends on ptw_pkg; one residue table lookup per byte unless the size is a power of two
`default_nettype none

module ptw_frame_mod #(
	parameter int TABLE_FRAMES = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [ptw_pkg::FRAME_NUM_W-1:0]     value,
	output logic                                     done,
	output logic      [$clog2(TABLE_FRAMES)-1:0]     result
);

	localparam int FRAME_W = $clog2(TABLE_FRAMES);
	localparam bit IS_POW2 = (TABLE_FRAMES & (TABLE_FRAMES - 1)) == 0;
	localparam int CHUNK_W = 8;

	// 2^(8*chunk) mod TABLE_FRAMES, evaluated at elaboration only
	function automatic int chunk_weight(input int chunk);
		int w;
		int i;
		w = 1 % TABLE_FRAMES;
		for (i = 0; i < CHUNK_W * chunk; i++)
			w = (w * 2) % TABLE_FRAMES;
		return w;
	endfunction

	if (IS_POW2) begin : g_pow2
		logic [FRAME_W-1:0] res_q;
		logic               done_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				res_q <= value[FRAME_W-1:0];
			end
		end

		assign done   = done_q;
		assign result = res_q;
	end else begin : g_table
		localparam int CHUNKS = ptw_pkg::FRAME_NUM_W / CHUNK_W;
		localparam int SEL_W  = $clog2(CHUNKS);
		localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(CHUNKS - 1);
		localparam logic [FRAME_W:0] MODULUS = (FRAME_W + 1)'(TABLE_FRAMES);

		logic [CHUNKS-1:0][(1 << CHUNK_W)-1:0][FRAME_W-1:0] residue;
		logic [ptw_pkg::FRAME_NUM_W-1:0] val_q;
		logic [FRAME_W-1:0]              acc_q;
		logic [SEL_W-1:0]                sel_q;
		logic                            busy_q;
		logic                            done_q;
		logic [FRAME_W:0]                sum;
		logic [FRAME_W:0]                reduced;

		// residue[j][b] is (b * 2^(8*j)) mod TABLE_FRAMES
		for (genvar j = 0; j < CHUNKS; j++) begin : g_chunk
			localparam int WEIGHT = chunk_weight(j);
			for (genvar b = 0; b < (1 << CHUNK_W); b++) begin : g_entry
				assign residue[j][b] = FRAME_W'((b * WEIGHT) % TABLE_FRAMES);
			end
		end

		// one byte per cycle, low byte first: acc = (acc + residue) mod N
		assign sum     = {1'b0, acc_q} + {1'b0, residue[sel_q][val_q[CHUNK_W-1:0]]};
		assign reduced = (sum >= MODULUS) ? (sum - MODULUS) : sum;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				sel_q  <= '0;
			end else begin
				done_q <= busy_q && !start && (sel_q == SEL_LAST);
				if (start) begin
					busy_q <= 1'b1;
					sel_q  <= '0;
				end else if (busy_q) begin
					sel_q <= sel_q + 1'b1;
					if (sel_q == SEL_LAST) begin
						busy_q <= 1'b0;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				val_q <= value;
				acc_q <= '0;
			end else if (busy_q) begin
				val_q <= val_q >> CHUNK_W;
				acc_q <= reduced[FRAME_W-1:0];
			end
		end

		assign done   = done_q;
		assign result = acc_q;
	end

endmodule

`default_nettype wire

// File: hw/rtl/ptw_walk_seq.sv
// ptw_walk_seq: sequencer for clearing, walking, allocating and responding
// depends on ptw_pkg, ptw_if; drives the frame store and the modulo unit
`default_nettype none

module ptw_walk_seq #(
	parameter int TABLE_FRAMES = 64
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	ptw_req_if.sink                                           req,
	ptw_rsp_if.source                                         rsp,
	input  wire logic [ptw_pkg::CFG_W-1:0]                    root_frame,
	input  wire logic [ptw_pkg::CFG_W-1:0]                    alloc_base,
	output logic                                              mem_we,
	output logic                                              mem_re,
	output logic [$clog2(TABLE_FRAMES)+ptw_pkg::ENTRY_IDX_W-1:0] mem_addr,
	output logic [ptw_pkg::ENTRY_W-1:0]                       mem_wdata,
	input  wire logic [ptw_pkg::ENTRY_W-1:0]                  mem_rdata,
	output logic                                              mod_start,
	output logic [ptw_pkg::FRAME_NUM_W-1:0]                   mod_value,
	input  wire logic                                         mod_done,
	input  wire logic [$clog2(TABLE_FRAMES)-1:0]              mod_result
);

	localparam int FRAME_W = $clog2(TABLE_FRAMES);
	localparam int ADDR_W  = FRAME_W + ptw_pkg::ENTRY_IDX_W;
	localparam int CNT_W   = $clog2(TABLE_FRAMES + 1);
	localparam int SUM_W   = ((CNT_W > ptw_pkg::CFG_W) ? CNT_W : ptw_pkg::CFG_W) + 1;
	localparam logic [SUM_W-1:0] FRAMES_LIMIT = SUM_W'(TABLE_FRAMES);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_EVAL,
		S_ZERO,
		S_LINK,
		S_RESP
	} state_t;

	state_t                                state_q;
	logic [ADDR_W-1:0]                     clr_q;
	logic [CNT_W-1:0]                      frames_q;
	logic [ptw_pkg::LEVEL_W-1:0]           level_q;
	logic [FRAME_W-1:0]                    frame_q;
	logic [FRAME_W-1:0]                    new_frame_q;
	logic [ADDR_W-1:0]                     slot_q;
	logic [ptw_pkg::OP_W-1:0]              op_q;
	logic [ptw_pkg::VA_W-1:0]              va_q;
	logic [ptw_pkg::FRAME_NUM_W-1:0]       pa_frame_q;
	logic [ptw_pkg::FLAGS_W-1:0]           flags_q;
	logic [ptw_pkg::STATUS_W-1:0]          res_status_q;
	logic [ptw_pkg::PA_W-1:0]              res_addr_q;
	logic                                  res_inv_q;
	logic                                  rsp_valid_q;
	logic [ptw_pkg::STATUS_W-1:0]          rsp_status_q;
	logic [ptw_pkg::PA_W-1:0]              rsp_addr_q;
	logic                                  rsp_inv_q;

	logic                                  accept;
	logic                                  op_valid;
	logic                                  present;
	logic                                  last_level;
	logic                                  rsp_load;
	logic [SUM_W-1:0]                      alloc_sum;
	logic [ADDR_W-1:0]                     walk_addr;
	logic [ptw_pkg::ENTRY_W-1:0]           map_entry;
	logic [ptw_pkg::ENTRY_W-1:0]           link_entry;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign op_valid   = (req.operation == ptw_pkg::OP_MAP) ||
		(req.operation == ptw_pkg::OP_UNMAP) || (req.operation == ptw_pkg::OP_RESOLVE);
	assign present    = mem_rdata[ptw_pkg::PTE_PRESENT];
	assign last_level = (level_q == ptw_pkg::LAST_LEVEL);
	assign rsp_load   = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);
	assign alloc_sum  = SUM_W'(alloc_base) + SUM_W'(frames_q);
	assign walk_addr  = {frame_q, ptw_pkg::level_index(va_q, level_q)};

	assign map_entry = {12'd0, pa_frame_q, 12'd0} | flags_q |
		ptw_pkg::ENTRY_W'(1 << ptw_pkg::PTE_PRESENT);
	assign link_entry = {12'd0, ptw_pkg::FRAME_NUM_W'(new_frame_q), 12'd0} |
		ptw_pkg::ENTRY_W'((1 << ptw_pkg::PTE_PRESENT) | (1 << ptw_pkg::PTE_WRITE));

	// modulo unit: root frame on accept, child pointer on a present entry
	assign mod_start = (accept && op_valid) ||
		(state_q == S_EVAL && !last_level && present);
	assign mod_value = (state_q == S_IDLE) ? ptw_pkg::FRAME_NUM_W'(root_frame) :
		mem_rdata[ptw_pkg::FRAME_NUM_W+ptw_pkg::PAGE_OFS_W-1:ptw_pkg::PAGE_OFS_W];

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = slot_q;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_READ: begin
				mem_re   = 1'b1;
				mem_addr = walk_addr;
			end
			S_EVAL: begin
				if (last_level) begin
					if (op_q == ptw_pkg::OP_MAP) begin
						mem_we    = 1'b1;
						mem_wdata = map_entry;
					end else if (op_q == ptw_pkg::OP_UNMAP && present) begin
						mem_we = 1'b1;
					end
				end
			end
			S_ZERO: begin
				mem_we   = 1'b1;
				mem_addr = {new_frame_q, clr_q[ptw_pkg::ENTRY_IDX_W-1:0]};
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_wdata = link_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			frames_q    <= '0;
			level_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q       <= req.operation;
						va_q       <= req.virt_addr;
						pa_frame_q <= req.phys_addr[ptw_pkg::PA_W-1:ptw_pkg::PAGE_OFS_W];
						flags_q    <= req.entry_flags;
						level_q    <= '0;
						res_status_q <= ptw_pkg::ST_OK;
						res_addr_q   <= '0;
						res_inv_q    <= 1'b0;
						// unused operation code: answer at once, no action
						state_q <= op_valid ? S_MOD : S_RESP;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						frame_q <= mod_result;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					slot_q  <= walk_addr;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!last_level) begin
						if (present) begin
							level_q <= level_q + 1'b1;
							state_q <= S_MOD;
						end else if (op_q != ptw_pkg::OP_MAP) begin
							res_status_q <= ptw_pkg::ST_NOT_MAPPED;
							state_q      <= S_RESP;
						end else if (alloc_sum >= FRAMES_LIMIT) begin
							res_status_q <= ptw_pkg::ST_NO_FRAMES;
							state_q      <= S_RESP;
						end else begin
							new_frame_q <= alloc_sum[FRAME_W-1:0];
							frames_q    <= frames_q + 1'b1;
							clr_q       <= '0;
							state_q     <= S_ZERO;
						end
					end else begin
						state_q <= S_RESP;
						if (op_q == ptw_pkg::OP_MAP) begin
							res_inv_q <= 1'b1;
						end else if (!present) begin
							res_status_q <= ptw_pkg::ST_NOT_MAPPED;
						end else if (op_q == ptw_pkg::OP_UNMAP) begin
							res_inv_q <= 1'b1;
						end else begin
							res_addr_q <= {mem_rdata[ptw_pkg::PA_W-1:ptw_pkg::PAGE_OFS_W],
								va_q[ptw_pkg::PAGE_OFS_W-1:0]};
						end
					end
				end
				S_ZERO: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[ptw_pkg::ENTRY_IDX_W-1:0] == '1) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					// new table already lies inside the store, no reduction needed
					frame_q <= new_frame_q;
					level_q <= level_q + 1'b1;
					state_q <= S_READ;
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_addr_q   <= res_addr_q;
						rsp_inv_q    <= res_inv_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.status             = rsp_status_q;
	assign rsp.translated_address = rsp_addr_q;
	assign rsp.tlb_invalidate     = rsp_inv_q;

endmodule

`default_nettype wire

// File: hw/rtl/page_table_walker.sv
// Four-level page table walker over an internal store of TABLE_FRAMES frames
// of 512 64-bit entries. After reset the whole store, TABLE_FRAMES rounded up
// to a power of two frames, is cleared one entry per cycle; requests are held
// off meanwhile, configuration writes are taken at any time. One request is
// handled at a time. Each of the four levels costs a root or pointer reduction
// modulo TABLE_FRAMES (the low bits, registered, for a power-of-two size,
// otherwise one byte per cycle through constant residue tables) plus a store
// read and an evaluate step. Each new table allocated by a map costs clearing
// the frame and writing the link but skips the next reduction. The response
// sits in an output register, so the next request is taken while it waits.
// depends on ptw_pkg, ptw_if, ptw_store, ptw_frame_mod, ptw_walk_seq
`default_nettype none

module page_table_walker #(
	parameter int TABLE_FRAMES = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ptw_req_if.sink    req,
	ptw_rsp_if.source  rsp,
	ptw_cfg_if.sink    cfg
);

	localparam int FRAME_W = $clog2(TABLE_FRAMES);
	localparam int ADDR_W  = FRAME_W + ptw_pkg::ENTRY_IDX_W;

	logic [ptw_pkg::CFG_W-1:0]       root_frame_q;
	logic [ptw_pkg::CFG_W-1:0]       alloc_base_q;
	logic                            mem_we;
	logic                            mem_re;
	logic [ADDR_W-1:0]               mem_addr;
	logic [ptw_pkg::ENTRY_W-1:0]     mem_wdata;
	logic [ptw_pkg::ENTRY_W-1:0]     mem_rdata;
	logic                            mod_start;
	logic [ptw_pkg::FRAME_NUM_W-1:0] mod_value;
	logic                            mod_done;
	logic [FRAME_W-1:0]              mod_result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= ptw_pkg::ROOT_FRAME_RESET;
			alloc_base_q <= ptw_pkg::ALLOC_BASE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ptw_pkg::CFG_ROOT_FRAME: root_frame_q <= cfg.data;
				ptw_pkg::CFG_ALLOC_BASE: alloc_base_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	ptw_store #(
		.ADDR_W (ADDR_W),
		.DATA_W (ptw_pkg::ENTRY_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	ptw_frame_mod #(
		.TABLE_FRAMES (TABLE_FRAMES)
	) u_frame_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.done   (mod_done),
		.result (mod_result)
	);

	ptw_walk_seq #(
		.TABLE_FRAMES (TABLE_FRAMES)
	) u_walk_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.root_frame (root_frame_q),
		.alloc_base (alloc_base_q),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.mod_start  (mod_start),
		.mod_value  (mod_value),
		.mod_done   (mod_done),
		.mod_result (mod_result)
	);

endmodule

`default_nettype wire

// File: hw/rtl/ptw_checker.sv
// ptw_checker: port-level checks on the page table walker, bound to the top
// depends on ptw_pkg for widths and codes
`default_nettype none

module ptw_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             req_valid,
	input wire logic                             req_ready,
	input wire logic                             rsp_valid,
	input wire logic                             rsp_ready,
	input wire logic [ptw_pkg::STATUS_W-1:0]     rsp_status,
	input wire logic [ptw_pkg::PA_W-1:0]         rsp_translated_address,
	input wire logic                             rsp_tlb_invalidate
);

	// a pending response is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before transaction");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// invalidation only with status ok and no address, as on a successful map or unmap
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_tlb_invalidate |->
		rsp_status == ptw_pkg::ST_OK && rsp_translated_address == '0)
		else $error("invalidate with error status or address");

	// an address comes back only with status ok
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_translated_address != '0 |-> rsp_status == ptw_pkg::ST_OK)
		else $error("translated address with error status");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ptw_pkg::ST_OK ||
		rsp_status == ptw_pkg::ST_NOT_MAPPED || rsp_status == ptw_pkg::ST_NO_FRAMES)
		else $error("undefined status code");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.req_valid              (req.valid),
	.req_ready              (req.ready),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_status             (rsp.status),
	.rsp_translated_address (rsp.translated_address),
	.rsp_tlb_invalidate     (rsp.tlb_invalidate)
);

`default_nettype wire

// File: dv/ptw_checker.sv
// ptw_tb_checker: watches the request, response and configuration channels of the
// page table walker, keeps its own copy of the frame store and checks responses
// depends on ptw_pkg and the channel interfaces in ptw_if
module ptw_tb_checker #(
	parameter int TABLE_FRAMES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ptw_req_if        req,
	ptw_rsp_if        rsp,
	ptw_cfg_if        cfg,
	output int        mismatches,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptw_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PA_W-1:0]     addr;
		logic                inv;
	} walk_result_t;

	logic [ENTRY_W-1:0] frame_store [TABLE_FRAMES*ENTRIES_PER_TABLE];
	int                 frames_handed_out;
	logic [CFG_W-1:0]   root_sel;
	logic [CFG_W-1:0]   alloc_first;
	walk_result_t       walk_results [$];

	initial begin
		foreach (frame_store[i])
			frame_store[i] = '0;
		frames_handed_out = 0;
		root_sel = ROOT_FRAME_RESET;
		alloc_first = ALLOC_BASE_RESET;
		mismatches = 0;
		outstanding = 0;
	end

	// bump allocation, no protection of live frames
	function automatic bit take_frame(output int frame);
		int next;
		int i;
		frame = 0;
		next = int'(alloc_first) + frames_handed_out;
		if (next >= TABLE_FRAMES)
			return 1'b0;
		frames_handed_out++;
		for (i = 0; i < ENTRIES_PER_TABLE; i++)
			frame_store[next*ENTRIES_PER_TABLE + i] = '0;
		frame = next;
		return 1'b1;
	endfunction

	// walks the three upper levels and returns the leaf slot
	function automatic logic [STATUS_W-1:0] descend(
		input  logic [VA_W-1:0] va,
		input  bit              grow,
		output int              slot
	);
		int                 frame;
		int                 lvl;
		int                 idx;
		int                 nf;
		logic [ENTRY_W-1:0] e;
		slot = 0;
		frame = int'(root_sel) % TABLE_FRAMES;
		for (lvl = 0; lvl < 3; lvl++) begin
			idx = frame*ENTRIES_PER_TABLE + int'(va[VA_W-1-ENTRY_IDX_W*lvl -: ENTRY_IDX_W]);
			e = frame_store[idx];
			if (!e[PTE_PRESENT]) begin
				if (!grow)
					return ST_NOT_MAPPED;
				if (!take_frame(nf))
					return ST_NO_FRAMES;
				e = '0;
				e[PA_W-1:PAGE_OFS_W] = FRAME_NUM_W'(nf);
				e[PTE_PRESENT] = 1'b1;
				e[PTE_WRITE] = 1'b1;
				frame_store[idx] = e;
			end
			frame = int'(e[PA_W-1:PAGE_OFS_W] % TABLE_FRAMES);
		end
		slot = frame*ENTRIES_PER_TABLE + int'(va[20:12]);
		return ST_OK;
	endfunction

	function automatic walk_result_t apply_request(
		input logic [OP_W-1:0]    op,
		input logic [VA_W-1:0]    va,
		input logic [PA_W-1:0]    pa,
		input logic [FLAGS_W-1:0] flags
	);
		walk_result_t        r;
		int                  slot;
		logic [STATUS_W-1:0] st;
		r = '0;
		case (op)
			OP_MAP: begin
				st = descend(va, 1'b1, slot);
				if (st == ST_OK) begin
					frame_store[slot] = {{(ENTRY_W-PA_W){1'b0}}, pa[PA_W-1:PAGE_OFS_W],
						{PAGE_OFS_W{1'b0}}} | flags | 64'd1;
					r.inv = 1'b1;
				end else begin
					r.status = st;
				end
			end
			OP_UNMAP: begin
				st = descend(va, 1'b0, slot);
				if (st == ST_OK && frame_store[slot][PTE_PRESENT]) begin
					frame_store[slot] = '0;
					r.inv = 1'b1;
				end else begin
					r.status = ST_NOT_MAPPED;
				end
			end
			OP_RESOLVE: begin
				st = descend(va, 1'b0, slot);
				if (st == ST_OK && frame_store[slot][PTE_PRESENT])
					r.addr = {frame_store[slot][PA_W-1:PAGE_OFS_W], va[PAGE_OFS_W-1:0]};
				else
					r.status = ST_NOT_MAPPED;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : observe
		walk_result_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_ROOT_FRAME)
					root_sel = cfg.data;
				else
					alloc_first = cfg.data;
			end
			if (req.valid && req.ready)
				walk_results.push_back(apply_request(req.operation, req.virt_addr,
					req.phys_addr, req.entry_flags));
			if (rsp.valid && rsp.ready) begin
				if (walk_results.size() == 0) begin
					mismatches++;
					$display("%0t: response transaction with no request outstanding", $time);
				end else begin
					want = walk_results.pop_front();
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d got %0d", $time, want.status,
							rsp.status);
					end
					if (rsp.translated_address !== want.addr) begin
						mismatches++;
						$display("%0t: translated_address expected %h got %h", $time,
							want.addr, rsp.translated_address);
					end
					if (rsp.tlb_invalidate !== want.inv) begin
						mismatches++;
						$display("%0t: tlb_invalidate expected %b got %b", $time, want.inv,
							rsp.tlb_invalidate);
					end
				end
			end
			outstanding = walk_results.size();
		end
	end

endmodule

// File: dv/tb_page_table_walker.sv
// tb_page_table_walker: reset, register setup and map/unmap/resolve traffic
// for the page table walker, with random idling on both channels
// depends on ptw_pkg, ptw_if, ptw_tb_checker and the walker rtl
module tb_page_table_walker;
	timeunit 1ns;
	timeprecision 1ps;
	import ptw_pkg::*;

	localparam int FRAMES           = 64;
	localparam int QUIET_LIMIT      = 100000;
	localparam int RANDOM_PER_PHASE = 280;
	localparam int PHASES           = 5;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   outstanding;
	bit   calm;
	bit   squeeze;
	logic [ENTRY_IDX_W-1:0] lvl_pool [4][8];

	ptw_req_if req();
	ptw_rsp_if rsp();
	ptw_cfg_if cfg();

	page_table_walker #(.TABLE_FRAMES(FRAMES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	ptw_tb_checker #(.TABLE_FRAMES(FRAMES)) walk_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic issue(
		input logic [OP_W-1:0]    op,
		input logic [VA_W-1:0]    va,
		input logic [PA_W-1:0]    pa,
		input logic [FLAGS_W-1:0] flags
	);
		int pick;
		int gap;
		gap = 0;
		if (!calm) begin
			pick = $urandom_range(0, 99);
			if (pick >= 95)
				gap = $urandom_range(8, 40);
			else if (pick >= 70)
				gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.virt_addr <= va;
		req.phys_addr <= pa;
		req.entry_flags <= flags;
		do @(posedge clk); while (!req.ready);
	endtask

	// most addresses come from a few indexes per level so that paths are shared
	task automatic random_request();
		int                   pick;
		logic [OP_W-1:0]      op;
		logic [VA_W-1:0]      va;
		logic [PA_W-1:0]      pa;
		logic [FLAGS_W-1:0]   flags;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_MAP;
		else if (pick < 60)
			op = OP_UNMAP;
		else if (pick < 95)
			op = OP_RESOLVE;
		else
			op = OP_UNUSED;
		if ($urandom_range(0, 99) < 85)
			va = {lvl_pool[0][$urandom_range(0, 1)], lvl_pool[1][$urandom_range(0, 1)],
				lvl_pool[2][$urandom_range(0, 2)], lvl_pool[3][$urandom_range(0, 7)],
				12'($urandom)};
		else
			va = VA_W'({$urandom, $urandom});
		pa = PA_W'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 50)
			flags = {52'b0, 12'($urandom)};
		else if (pick < 80)
			flags = {$urandom, $urandom};
		else
			flags = '0;
		issue(op, va, pa, flags);
	endtask

	task automatic drain();
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// response side: mostly ready, some short stalls, a few long ones, one long hold-off
	initial begin
		int pick;
		int hold;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pick = $urandom_range(0, 99);
			if (squeeze) begin
				squeeze = 1'b0;
				hold = 400;
			end else if (calm || pick < 70) begin
				hold = 0;
			end else if (pick < 95) begin
				hold = $urandom_range(1, 4);
			end else begin
				hold = $urandom_range(20, 120);
			end
			if (hold == 0) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
					(cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] roots [PHASES];
		logic [CFG_W-1:0] bases [PHASES];
		int               phase;
		int               n;
		int               l;
		int               k;
		req.valid = 1'b0;
		req.operation = OP_MAP;
		req.virt_addr = '0;
		req.phys_addr = '0;
		req.entry_flags = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_ROOT_FRAME;
		cfg.data = '0;
		calm = 1'b0;
		squeeze = 1'b0;
		// reset values, all frames exhausted, root moved with base at zero,
		// a random mix, back to the defaults
		roots = '{6'd0, 6'd63, 6'd63, 6'd0, 6'd0};
		bases = '{6'd1, 6'd63, 6'd0, 6'd0, 6'd1};
		roots[3] = CFG_W'($urandom_range(0, 63));
		bases[3] = CFG_W'($urandom_range(0, 8));
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			write_reg(CFG_ROOT_FRAME, roots[phase]);
			write_reg(CFG_ALLOC_BASE, bases[phase]);
			@(negedge clk);
			cfg.valid <= 1'b0;
			for (l = 0; l < 4; l++)
				for (k = 0; k < 8; k++)
					lvl_pool[l][k] = ENTRY_IDX_W'($urandom);
			lvl_pool[3][0] = '0;
			lvl_pool[3][7] = '1;

			if (phase == 0) begin
				issue(OP_RESOLVE, '0, '0, '0);
				issue(OP_UNMAP, '0, '0, '0);
				issue(OP_MAP, '0, '0, '0);
				issue(OP_RESOLVE, '0, '0, '0);
				issue(OP_MAP, '1, '1, '0);
				issue(OP_RESOLVE, '1, '0, '0);
				issue(OP_MAP, 48'h0000_0000_1000, 52'h1_2345_6789_A000, '1);
				issue(OP_RESOLVE, 48'h0000_0000_1ABC, '0, '0);
				// remap of a present entry
				issue(OP_MAP, '0, 52'h0_00FE_DCBA_9000, 64'h8000_0000_0000_0002);
				issue(OP_RESOLVE, 48'h0000_0000_0123, '0, '0);
				issue(OP_UNMAP, '0, '0, '0);
				issue(OP_RESOLVE, '0, '0, '0);
				issue(OP_UNMAP, '0, '0, '0);
				// upper level absent
				issue(OP_UNMAP, 48'h8000_0000_0000, '0, '0);
				issue(OP_UNUSED, '1, '1, '1);
				issue(OP_UNUSED, '0, '0, '0);
				issue(OP_RESOLVE, 48'h7FFF_FFFF_F000, '0, '0);
				issue(OP_MAP, 48'h7FFF_FFFF_F000, 52'h8_0000_0000_0FFF, '0);
				issue(OP_RESOLVE, 48'h7FFF_FFFF_F555, '0, '0);
				issue(OP_UNMAP, '1, '0, '0);
			end

			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				calm = (n < 60);
				if (phase == 2 && n == 80)
					squeeze = 1'b1;
				random_request();
			end
			calm = 1'b0;
			@(negedge clk);
			req.valid <= 1'b0;
		end

		drain();
		repeat (50) @(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
